// ===== rtl/hlt_pkg.sv =====
// Shared constants, codes and types of the heartbeat liveness table.
package hlt_pkg;

  localparam int PEERS  = 16;
  localparam int SLOT_W = $clog2(PEERS);
  localparam int CNT_W  = $clog2(PEERS + 1);
  localparam int TIME_W = 48;
  localparam int SUM_W  = TIME_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;
  localparam logic [1:0] OP_RESPONSE = 2'd2;
  localparam logic [1:0] OP_CHECK    = 2'd3;

  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_UNREG   = 3'd1;
  localparam logic [2:0] ST_REQ     = 3'd2;
  localparam logic [2:0] ST_RESP    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_OFFLINE = 3'd5;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_OFFLINE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSES    = 2'd2;

  localparam logic [31:0] RESET_REGISTER_WAIT = 32'd10000;
  localparam logic [31:0] RESET_REPLY_TIMEOUT = 32'd3000;
  localparam logic [7:0]  RESET_MAX_MISSES    = 8'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        peer;
    logic              in_range;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [31:0] register_wait;
    logic [31:0] reply_timeout;
    logic [7:0]  max_misses;
  } cfg_t;

endpackage

// ===== rtl/hlt_intf.sv =====
// Valid/ready channel interfaces for operation items and result items.
interface hlt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  peer;
  logic [47:0] now;

  modport source (output valid, op, peer, now, input ready);
  modport sink (input valid, op, peer, now, output ready);
endinterface

interface hlt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] peer_id;
  logic       kind;
  logic       last;

  modport source (output valid, peer_id, kind, last, input ready);
  modport sink (input valid, peer_id, kind, last, output ready);
endinterface

// ===== rtl/hlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hlt_front.sv =====
// Front end: accept operation items, classify them and queue them as commands.
module hlt_front (
  input  logic           clk,
  input  logic           rst,
  hlt_in_if.sink         items,
  output logic           cmd_valid,
  output hlt_pkg::cmd_t  cmd,
  input  logic           cmd_ready
);
  import hlt_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       q [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  assign items.ready = (count != 2'(DEPTH));
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (count != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q[rd_ptr];

  // Classify: flag slots that exist in the table
  always_comb begin
    incoming.op       = items.op;
    incoming.peer     = items.peer;
    incoming.in_range = (int'(items.peer) < PEERS);
    incoming.now      = items.now;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/hlt_back.sv =====
// Back end: execute queued commands against the peer table and emit results.
module hlt_back (
  input  logic           clk,
  input  logic           rst,
  input  hlt_pkg::cfg_t  cfg,
  input  logic           cmd_valid,
  input  hlt_pkg::cmd_t  cmd,
  output logic           cmd_ready,
  hlt_out_if.source      results
);
  import hlt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state;
  logic [1:0]        cur_op;
  logic [TIME_W-1:0] cur_now;
  logic [CNT_W-1:0]  issue_cnt;
  logic              eval_valid;
  logic [SLOT_W-1:0] eval_idx;

  logic              hold_valid;
  logic [SLOT_W-1:0] hold_id;
  logic              hold_kind;

  logic              out_valid;
  logic [SLOT_W-1:0] out_id;
  logic              out_kind;
  logic              out_last;

  logic [2:0]        status [PEERS];
  logic [7:0]        misses [PEERS];

  logic              out_free;
  logic              pop;
  logic [SLOT_W-1:0] cmd_slot;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] issue_slot;
  logic [2:0]        cur_status;
  logic [7:0]        cur_miss;
  logic [7:0]        miss_inc;
  logic [TIME_W-1:0] reg_rdata;
  logic [TIME_W-1:0] req_rdata;
  logic [TIME_W-1:0] stamp;
  logic [31:0]       addend;
  logic              late;
  logic              produce;
  logic              res_kind;
  logic              st_we;
  logic [2:0]        st_new;
  logic              miss_we;
  logic              req_we;
  logic              reg_we;
  logic              stall;
  logic              eval_fire;
  logic              issuing;
  logic              scan_done;

  assign out_free   = !out_valid || results.ready;
  assign cmd_ready  = (state == S_IDLE);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd_slot   = SLOT_W'(cmd.peer);
  assign issue_slot = issue_cnt[SLOT_W-1:0];
  assign rd_idx     = (state == S_IDLE) ? cmd_slot : eval_idx;
  assign cur_status = status[rd_idx];
  assign cur_miss   = misses[rd_idx];
  assign miss_inc   = (cur_miss == 8'hFF) ? cur_miss : cur_miss + 8'd1;

  assign stall     = eval_valid && produce && hold_valid && !out_free;
  assign eval_fire = eval_valid && !stall;
  assign issuing   = (state == S_SCAN) && (issue_cnt < CNT_W'(PEERS)) && !stall;
  assign scan_done = (state == S_SCAN) && (issue_cnt == CNT_W'(PEERS)) && !eval_valid;
  assign reg_we    = pop && (cmd.op == OP_REGISTER) && cmd.in_range;

  // Decide the outcome for the slot in the evaluate stage
  always_comb begin
    produce  = 1'b0;
    res_kind = KIND_REQUEST;
    st_we    = 1'b0;
    st_new   = cur_status;
    miss_we  = 1'b0;
    req_we   = 1'b0;
    stamp    = (cur_status == ST_UNREG) ? reg_rdata : req_rdata;
    addend   = (cur_status == ST_UNREG) ? cfg.register_wait : cfg.reply_timeout;
    late     = (({1'b0, stamp} + SUM_W'(addend)) < {1'b0, cur_now});
    case (cur_op)
      OP_REQUEST: begin
        if (cur_status inside {ST_REQ, ST_RESP, ST_TIMEOUT}) begin
          produce = 1'b1;
          st_we   = 1'b1;
          st_new  = ST_REQ;
          req_we  = 1'b1;
        end
      end
      OP_CHECK: begin
        if (cur_status == ST_UNREG && late) begin
          produce  = 1'b1;
          res_kind = KIND_OFFLINE;
          st_we    = 1'b1;
          st_new   = ST_OFFLINE;
        end else if (cur_status == ST_REQ && late) begin
          miss_we = 1'b1;
          st_we   = 1'b1;
          if (miss_inc > cfg.max_misses) begin
            st_new   = ST_OFFLINE;
            produce  = 1'b1;
            res_kind = KIND_OFFLINE;
          end else begin
            st_new = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  hlt_ram #(.WIDTH(TIME_W), .DEPTH(PEERS)) u_reg_stamp (
    .clk   (clk),
    .we    (reg_we),
    .waddr (cmd_slot),
    .wdata (cmd.now),
    .re    (issuing),
    .raddr (issue_slot),
    .rdata (reg_rdata)
  );

  hlt_ram #(.WIDTH(TIME_W), .DEPTH(PEERS)) u_req_stamp (
    .clk   (clk),
    .we    (eval_fire && req_we),
    .waddr (eval_idx),
    .wdata (cur_now),
    .re    (issuing),
    .raddr (issue_slot),
    .rdata (req_rdata)
  );

  // Table status and miss counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PEERS; i++) begin
        status[i] <= ST_EMPTY;
        misses[i] <= 8'd0;
      end
    end else begin
      if (pop && cmd.in_range) begin
        case (cmd.op)
          OP_REGISTER: begin
            status[cmd_slot] <= ST_UNREG;
            misses[cmd_slot] <= 8'd0;
          end
          OP_RESPONSE: begin
            if (cur_status != ST_EMPTY && cur_status != ST_OFFLINE) begin
              status[cmd_slot] <= ST_RESP;
              misses[cmd_slot] <= 8'd0;
            end
          end
          default: ;
        endcase
      end
      if (eval_fire && st_we) begin
        status[eval_idx] <= st_new;
      end
      if (eval_fire && miss_we) begin
        misses[eval_idx] <= miss_inc;
      end
    end
  end

  // Sequencer and scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_cnt  <= '0;
      eval_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop && (cmd.op == OP_REQUEST || cmd.op == OP_CHECK)) begin
            issue_cnt <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_cnt  <= issue_cnt + CNT_W'(1);
            eval_valid <= 1'b1;
          end else if (eval_fire) begin
            eval_valid <= 1'b0;
          end
          if (scan_done) begin
            state <= hold_valid ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op  <= cmd.op;
      cur_now <= cmd.now;
    end
    if (issuing) begin
      eval_idx <= issue_slot;
    end
  end

  // Hold the newest result back one step so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (eval_fire && produce) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
        hold_valid <= 1'b1;
      end
      if (state == S_FLUSH && out_free) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire && produce) begin
      if (hold_valid) begin
        out_id   <= hold_id;
        out_kind <= hold_kind;
        out_last <= 1'b0;
      end
      hold_id   <= eval_idx;
      hold_kind <= res_kind;
    end
    if (state == S_FLUSH && out_free) begin
      out_id   <= hold_id;
      out_kind <= hold_kind;
      out_last <= 1'b1;
    end
  end

  assign results.valid   = out_valid;
  assign results.peer_id = 4'(out_id);
  assign results.kind    = out_kind;
  assign results.last    = out_last;

endmodule

// ===== rtl/heartbeat_liveness_table.sv =====
// Top level of the heartbeat liveness table: configuration, front end and back end.
//
// Keeps the liveness of PEERS (16) peer slots. Each item on the items channel
// carries one operation: register, request round, response or check scan.
// Register and response are executed by the back end once they leave the
// two-entry command queue, and produce no result. A request round and a check
// scan walk every slot once through a two-stage pipeline (stamp RAM read, then
// evaluate), one slot at a time through the single read port of each stamp RAM;
// the back end takes no new command until the walk ends and any held result
// has passed to the output register. Results come out in rising slot order,
// one beat each, with last set on the final beat of an operation; an
// operation with nothing to report sends no beat. The most recent result is
// held back until the next one or the end of the walk so that last can be
// set, and a stalled results channel pauses the walk without losing anything.
// The front end keeps taking items while the back end is busy, until its
// queue is full. The stamp stores are not cleared at reset; they are always
// written before their contents are used. Write configuration through
// cfg_we / cfg_idx / cfg_data only while the block is idle.
module heartbeat_liveness_table (
  input  logic                            clk,
  input  logic                            rst,
  hlt_in_if.sink                          items,
  hlt_out_if.source                       results,
  input  logic                            cfg_we,
  input  logic [hlt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hlt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hlt_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Configuration registers; writes to an unknown index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.register_wait <= RESET_REGISTER_WAIT;
      cfg.reply_timeout <= RESET_REPLY_TIMEOUT;
      cfg.max_misses    <= RESET_MAX_MISSES;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REGISTER_WAIT: cfg.register_wait <= cfg_data;
        CFG_REPLY_TIMEOUT: cfg.reply_timeout <= cfg_data;
        CFG_MAX_MISSES:    cfg.max_misses    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Accept and classify items, queue them as commands
  hlt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Execute commands against the table, drive the result beats
  hlt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .results   (results)
  );

  // Reset leaves no result beat and no queued command behind
  assert property (@(posedge clk) rst |=> !results.valid && !cmd_valid)
    else $error("result or command pending after reset");

  // A scan command makes the back end busy, so it does not take a command straight after starting it
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.op == OP_REQUEST || cmd.op == OP_CHECK)
    |=> !cmd_ready)
    else $error("back end took a command straight after starting a scan");

  // The front end only refuses items when it holds queued commands
  assert property (@(posedge clk) disable iff (rst) !items.ready |-> cmd_valid)
    else $error("items refused with an empty command queue");

endmodule
